FILE: design/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
package stbs_pkg;

  localparam int TableDepth = 256;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int PtrW       = AddrW + 1;
  localparam int DataW      = 32;
  localparam int CmdW       = 3;
  localparam int IdxW       = 8;
  localparam int PosW       = 8;
  localparam int OccW       = 9;

  typedef enum logic [CmdW-1:0] {
    CmdWrite = 3'd0,
    CmdExact = 3'd1,
    CmdFirst = 3'd2,
    CmdLast  = 3'd3,
    CmdCount = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StatWritten = 2'd0,
    StatFound   = 2'd1,
    StatMissing = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StateIdle,
    StateSearch,
    StateDone
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [PosW-1:0]     position;
    logic [OccW-1:0]     occurrences;
  } result_t;

endpackage

FILE: design/stbs_if.sv
// command and response channel interfaces
interface stbs_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [stbs_pkg::CmdW-1:0]         command;
  logic [stbs_pkg::IdxW-1:0]         entry_index;
  logic signed [stbs_pkg::DataW-1:0] key;
  logic [stbs_pkg::IdxW-1:0]         range_low;
  logic [stbs_pkg::IdxW-1:0]         range_high;

  modport source (output valid, command, entry_index, key, range_low, range_high,
                  input ready);
  modport sink (input valid, command, entry_index, key, range_low, range_high,
                output ready);
endinterface

interface stbs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [stbs_pkg::PosW-1:0] position;
  logic [stbs_pkg::OccW-1:0] occurrences;

  modport source (output valid, status, position, occurrences, input ready);
  modport sink (input valid, status, position, occurrences, output ready);
endinterface

FILE: design/stbs_engine.sv
// table memory and binary search sequencer, one probe per cycle
module stbs_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  stbs_cmd_if.sink          cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output stbs_pkg::result_t res_o
);
  import stbs_pkg::*;

  logic [DataW-1:0] mem [TableDepth];
  logic [DataW-1:0] rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] rd_addr;

  state_e                  state_q, state_d;
  cmd_e                    mode_q, mode_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic [PtrW-1:0]         lo_q, lo_d, hip_q, hip_d, lo0_q, lo0_d, hip0_q, hip0_d;
  logic [AddrW-1:0]        mid_q, mid_d, hitpos_q, hitpos_d, first_q, first_d;
  logic                    hit_q, hit_d, second_q, second_d;
  result_t                 res_q, res_d;

  logic [PtrW-1:0]  in_lo, in_hip, nlo, nhip;
  logic             in_empty;
  logic             cmp_eq, cmp_lt, stop;
  logic [PtrW-1:0]  occ_w;

  // midpoint of [lo, hip - 1], caller guarantees lo < hip
  function automatic logic [AddrW-1:0] mid_of(input logic [PtrW-1:0] lo,
                                              input logic [PtrW-1:0] hip);
    logic [PtrW-1:0] span;
    span = hip - lo - PtrW'(1);
    return AddrW'(lo + (span >> 1));
  endfunction

  // range_high clamps to the last entry, kept as one past the end
  assign in_lo    = (int'(cmd_i.range_low) >= TableDepth) ? PtrW'(TableDepth)
                                                          : PtrW'(cmd_i.range_low);
  assign in_hip   = (int'(cmd_i.range_high) >= TableDepth) ? PtrW'(TableDepth)
                                                           : PtrW'(cmd_i.range_high) + PtrW'(1);
  assign in_empty = in_lo >= in_hip;

  assign cmp_eq = $signed(rdata_q) == key_q;
  assign cmp_lt = $signed(rdata_q) < key_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AddrW'(cmd_i.entry_index)] <= cmd_i.key;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hip_d       = hip_q;
    lo0_d       = lo0_q;
    hip0_d      = hip0_q;
    mid_d       = mid_q;
    hitpos_d    = hitpos_q;
    first_d     = first_q;
    hit_d       = hit_q;
    second_d    = second_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    rd_addr     = mid_q;
    nlo         = lo_q;
    nhip        = hip_q;
    stop        = 1'b0;
    occ_w       = '0;
    cmd_i.ready = state_q == StateIdle;
    res_valid_o = state_q == StateDone;

    case (state_q)
      StateIdle: begin
        if (cmd_i.valid) begin
          mode_d   = cmd_e'(cmd_i.command);
          key_d    = cmd_i.key;
          lo_d     = in_lo;
          hip_d    = in_hip;
          lo0_d    = in_lo;
          hip0_d   = in_hip;
          hit_d    = 1'b0;
          second_d = 1'b0;
          res_d    = '{status: StatMissing, position: '0, occurrences: '0};
          case (cmd_e'(cmd_i.command))
            CmdWrite: begin
              mem_we       = int'(cmd_i.entry_index) < TableDepth;
              res_d.status = StatWritten;
              state_d      = StateDone;
            end
            CmdExact, CmdFirst, CmdLast, CmdCount: begin
              if (in_empty) begin
                state_d = StateDone;
              end else begin
                mid_d   = mid_of(in_lo, in_hip);
                rd_addr = mid_of(in_lo, in_hip);
                state_d = StateSearch;
              end
            end
            default: begin
              state_d = StateDone;
            end
          endcase
        end
      end

      StateSearch: begin
        // read data belongs to the probe issued at mid_q last cycle
        if (cmp_eq) begin
          hit_d    = 1'b1;
          hitpos_d = mid_q;
          if (mode_q == CmdExact) begin
            stop  = 1'b1;
            res_d = '{status: StatFound, position: PosW'(mid_q), occurrences: '0};
            state_d = StateDone;
          end else if (mode_q == CmdFirst || (mode_q == CmdCount && !second_q)) begin
            nhip = PtrW'(mid_q);
          end else begin
            nlo = PtrW'(mid_q) + PtrW'(1);
          end
        end else if (cmp_lt) begin
          nlo = PtrW'(mid_q) + PtrW'(1);
        end else begin
          nhip = PtrW'(mid_q);
        end

        lo_d    = nlo;
        hip_d   = nhip;
        mid_d   = mid_of(nlo, nhip);
        rd_addr = mid_of(nlo, nhip);

        if (!stop && nlo >= nhip) begin
          state_d = StateDone;
          res_d   = '{status: StatMissing, position: '0, occurrences: '0};
          case (mode_q)
            CmdFirst, CmdLast: begin
              if (hit_d) begin
                res_d.status   = StatFound;
                res_d.position = PosW'(hitpos_d);
              end
            end
            CmdCount: begin
              if (!second_q) begin
                if (hit_d) begin
                  // rerun over the same range looking for the last match
                  first_d  = hitpos_d;
                  second_d = 1'b1;
                  hit_d    = 1'b0;
                  lo_d     = lo0_q;
                  hip_d    = hip0_q;
                  mid_d    = mid_of(lo0_q, hip0_q);
                  rd_addr  = mid_of(lo0_q, hip0_q);
                  state_d  = StateSearch;
                end
              end else if (hit_d && hitpos_d >= first_q) begin
                occ_w             = PtrW'(hitpos_d) - PtrW'(first_q) + PtrW'(1);
                res_d.status      = StatFound;
                res_d.occurrences = OccW'(occ_w);
              end
            end
            default: begin
            end
          endcase
        end
      end

      StateDone: begin
        if (res_ready_i) begin
          state_d = StateIdle;
        end
      end

      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StateIdle;
      hit_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      hit_q    <= hit_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hip_q    <= hip_d;
    lo0_q    <= lo0_d;
    hip0_q   <= hip0_d;
    mid_q    <= mid_d;
    hitpos_q <= hitpos_d;
    first_q  <= first_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: design/sorted_table_binary_search.sv
// a write is answered through the sequencer done state and the response register; a search
// makes one table read per probe, up to 9 probes per pass over 256 entries, count runs two passes
// throughput: one command at a time, next command accepted the cycle after the response
// leaves the sequencer; the response register lets it wait while the next command starts
// reset clears the sequencer and response valid; table contents are undefined until written
module sorted_table_binary_search (
  input  logic       clk_i,
  input  logic       rst_ni,
  stbs_cmd_if.sink   cmd_i,
  stbs_rsp_if.source rsp_o
);
  import stbs_pkg::*;

  logic    eng_valid, eng_ready;
  result_t eng_res;
  logic    rsp_valid_q, rsp_valid_d;
  result_t rsp_q, rsp_d;

  stbs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_valid_o (eng_valid),
    .res_ready_i (eng_ready),
    .res_o       (eng_res)
  );

  // response register parts the sequencer from the downstream stall
  assign eng_ready = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (eng_ready) begin
      rsp_valid_d = eng_valid;
      if (eng_valid) begin
        rsp_d = eng_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.position    = rsp_q.position;
  assign rsp_o.occurrences = rsp_q.occurrences;

`ifndef SYNTHESIS
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_valid |-> !cmd_i.ready)
    else $error("sequencer offers a word while taking commands");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready && cmd_i.command == CmdWrite)
      |=> (eng_valid && eng_res.status == StatWritten))
    else $error("write did not complete in one cycle");

  a_write_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == StatWritten)
      |-> (rsp_o.position == '0 && rsp_o.occurrences == '0))
    else $error("write response carries search fields");

  a_count_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.occurrences != '0)
      |-> (rsp_o.status == StatFound && rsp_o.position == '0))
    else $error("count response malformed");
`endif

endmodule
